// ===== rtl/smvm_pkg.sv =====
package smvm_pkg;

    localparam int IN_DIM = 1024;
    localparam int ADDR_W = $clog2(IN_DIM);

    localparam int IDX_W  = 10;
    localparam int VAL_W  = 16;
    localparam int PROD_W = 2 * VAL_W;
    localparam int SUM_W  = 40;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam int ODEPTH = 4;
    localparam int OPTR_W = $clog2(ODEPTH);
    localparam int OCNT_W = $clog2(ODEPTH + 1);

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_TERM = 1'b1;

    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    typedef struct packed {
        logic signed [VAL_W-1:0] elem;
        logic signed [VAL_W-1:0] weight;
        logic                    in_range;
        logic                    last;
    } term_t;

    typedef struct packed {
        logic [QCNT_W-1:0] count;
        logic              empty;
    } q_status_t;

endpackage

// ===== rtl/smvm_front.sv =====
module smvm_front
    import smvm_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  logic                    mode,
    input  logic [IDX_W-1:0]        index,
    input  logic signed [VAL_W-1:0] value,
    input  logic                    row_end,
    input  q_status_t               q_status,
    output logic                    full,
    output logic                    term_valid,
    output term_t                   term
);

    logic signed [VAL_W-1:0] vec_mem [IN_DIM];

    logic                    term_valid_reg;
    logic                    term_valid_next;
    logic signed [VAL_W-1:0] elem_reg;
    logic signed [VAL_W-1:0] weight_reg;
    logic                    in_range_reg;
    logic                    last_reg;

    logic             accept;
    logic             in_range;
    logic [ADDR_W-1:0] addr;

    // one slot in the queue is kept for the term in flight
    assign full = term_valid_reg ? (q_status.count >= QCNT_W'(QDEPTH - 1))
                                 : (q_status.count >= QCNT_W'(QDEPTH));

    assign accept   = push && !full;
    assign in_range = 32'(index) < 32'(IN_DIM);
    assign addr     = ADDR_W'(index);

    assign term_valid_next = accept && (mode == MODE_TERM);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            term_valid_reg <= 1'b0;
        end
        else
        begin
            term_valid_reg <= term_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && (mode == MODE_LOAD) && in_range)
        begin
            vec_mem[addr] <= value;
        end
        if (term_valid_next)
        begin
            elem_reg     <= vec_mem[addr];
            weight_reg   <= value;
            in_range_reg <= in_range;
            last_reg     <= row_end;
        end
    end

    assign term_valid = term_valid_reg;
    assign term = '{elem: elem_reg, weight: weight_reg, in_range: in_range_reg,
                    last: last_reg};

endmodule

// ===== rtl/smvm_queue.sv =====
module smvm_queue
    import smvm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  term_t     push_data,
    input  logic      pop,
    output term_t     head,
    output q_status_t status
);

    term_t buf_mem [QDEPTH];

    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0
                                                                  : wr_ptr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0
                                                                  : rd_ptr_reg + QPTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_mem[wr_ptr_reg] <= push_data;
        end
    end

    assign head         = buf_mem[rd_ptr_reg];
    assign status.count = count_reg;
    assign status.empty = (count_reg == '0);

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == QCNT_W'(QDEPTH)) |-> (!push || pop))
        else $error("term queue overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (count_reg != '0))
        else $error("term queue underflow");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QDEPTH))
        else $error("term queue count out of range");
`endif

endmodule

// ===== rtl/smvm_back.sv =====
module smvm_back
    import smvm_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  term_t                   head,
    input  q_status_t               q_status,
    output logic                    q_pop,
    input  logic                    pop,
    output logic                    empty,
    output logic signed [SUM_W-1:0] row_sum
);

    logic signed [SUM_W-1:0] out_mem [ODEPTH];

    logic                     prod_valid_reg;
    logic                     prod_last_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [SUM_W-1:0]  acc_reg;
    logic signed [SUM_W-1:0]  acc_next;

    logic [OPTR_W-1:0] wr_ptr_reg;
    logic [OPTR_W-1:0] rd_ptr_reg;
    logic [OCNT_W-1:0] out_count_reg;
    logic [OCNT_W-1:0] out_count_next;

    logic                     room;
    logic signed [VAL_W-1:0]  elem_use;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [SUM_W:0]    sum_wide;
    logic signed [SUM_W-1:0]  sum_sat;
    logic                     out_push;
    logic                     out_pop;

    // a row end already in the multiplier holds one result slot
    assign room = (prod_valid_reg && prod_last_reg)
                  ? (out_count_reg < OCNT_W'(ODEPTH - 1))
                  : (out_count_reg < OCNT_W'(ODEPTH));

    assign q_pop = !q_status.empty && room;

    assign elem_use  = head.in_range ? head.elem : '0;
    assign prod_next = PROD_W'(elem_use) * PROD_W'(head.weight);

    assign sum_wide = (SUM_W+1)'(acc_reg) + (SUM_W+1)'(prod_reg);

    always_comb
    begin
        if (sum_wide > (SUM_W+1)'(SUM_MAX))
        begin
            sum_sat = SUM_MAX;
        end
        else if (sum_wide < (SUM_W+1)'(SUM_MIN))
        begin
            sum_sat = SUM_MIN;
        end
        else
        begin
            sum_sat = sum_wide[SUM_W-1:0];
        end
    end

    assign out_push = prod_valid_reg && prod_last_reg;
    assign out_pop  = pop && (out_count_reg != '0);

    always_comb
    begin
        acc_next = acc_reg;
        if (prod_valid_reg)
        begin
            acc_next = prod_last_reg ? '0 : sum_sat;
        end
    end

    always_comb
    begin
        out_count_next = out_count_reg;
        if (out_push && !out_pop)
        begin
            out_count_next = out_count_reg + OCNT_W'(1);
        end
        else if (out_pop && !out_push)
        begin
            out_count_next = out_count_reg - OCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            acc_reg        <= '0;
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            out_count_reg  <= '0;
        end
        else
        begin
            prod_valid_reg <= q_pop;
            acc_reg        <= acc_next;
            if (out_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == OPTR_W'(ODEPTH - 1)) ? '0
                                                                  : wr_ptr_reg + OPTR_W'(1);
            end
            if (out_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == OPTR_W'(ODEPTH - 1)) ? '0
                                                                  : rd_ptr_reg + OPTR_W'(1);
            end
            out_count_reg <= out_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            prod_reg      <= prod_next;
            prod_last_reg <= head.last;
        end
        if (out_push)
        begin
            out_mem[wr_ptr_reg] <= sum_sat;
        end
    end

    assign empty   = (out_count_reg == '0);
    assign row_sum = out_mem[rd_ptr_reg];

`ifndef SYNTHESIS
    a_out_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        out_push |-> ((out_count_reg < OCNT_W'(ODEPTH)) || out_pop))
        else $error("result queue overflow");

    a_acc_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        out_push |=> (acc_reg == '0))
        else $error("accumulator not cleared after row end");

    a_out_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_count_reg <= OCNT_W'(ODEPTH))
        else $error("result count out of range");
`endif

endmodule

// ===== rtl/sparse_matrix_vector_multiply_core.sv =====
// Streams one row of a sparse matrix times a dense vector. Load items (mode 0) write one
// Q4.12 element of the input vector; weight items (mode 1) add vector[index] * weight into
// a saturating 40-bit Q16.24 accumulator, and the item marked row_end releases the row sum
// and clears the accumulator. One item is accepted every cycle while full is low; a row-end
// item passes the term register, the term queue and the multiplier register before its
// row sum is written into the result queue. A four-entry term queue and a four-entry
// result queue let either side stall alone; full rises only when the term queue lacks room.
// A weight term must only address vector entries that were loaded since reset.
module sparse_matrix_vector_multiply_core
    import smvm_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    output logic                    full,
    input  logic                    mode,
    input  logic [IDX_W-1:0]        index,
    input  logic signed [VAL_W-1:0] value,
    input  logic                    row_end,
    output logic                    empty,
    input  logic                    pop,
    output logic signed [SUM_W-1:0] row_sum
);

    logic      term_valid;
    term_t     term;
    term_t     head;
    q_status_t q_status;
    logic      q_pop;

    smvm_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .mode       (mode),
        .index      (index),
        .value      (value),
        .row_end    (row_end),
        .q_status   (q_status),
        .full       (full),
        .term_valid (term_valid),
        .term       (term)
    );

    smvm_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (term_valid),
        .push_data (term),
        .pop       (q_pop),
        .head      (head),
        .status    (q_status)
    );

    smvm_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .q_status (q_status),
        .q_pop    (q_pop),
        .pop      (pop),
        .empty    (empty),
        .row_sum  (row_sum)
    );

endmodule
